/* design/qdlb_pkg.sv */
`default_nettype none
package qdlb_pkg;

  localparam int QUAD_VERTS   = 4;
  localparam int QUAD_INDICES = 6;

  localparam logic [16:0] VERTEX_BUDGET_RST  = 17'd65536;
  localparam logic [17:0] INDEX_BUDGET_RST   = 18'd131072;
  localparam logic [12:0] COMMAND_BUDGET_RST = 13'd4096;

  typedef enum logic [1:0] {
    CFG_VERTEX_BUDGET  = 2'd0,
    CFG_INDEX_BUDGET   = 2'd1,
    CFG_COMMAND_BUDGET = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FUNC_ADD      = 2'd0,
    FUNC_MARK     = 2'd1,
    FUNC_ROLLBACK = 2'd2,
    FUNC_CLEAR    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_VERTEX  = 3'd0,
    KIND_INDEX   = 3'd1,
    KIND_NEW_CMD = 3'd2,
    KIND_CMD_UPD = 3'd3,
    KIND_STATUS  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_VERTEX     = 3'd1,
    ST_INDEX      = 3'd2,
    ST_COMMAND    = 3'd3,
    ST_DEGENERATE = 3'd4,
    ST_BAD_MARK   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    OS_NONE,
    OS_VERTEX,
    OS_INDEX,
    OS_COMMAND,
    OS_STATUS,
    OS_ROLLBACK
  } oksel_e;

  typedef enum logic [1:0] {
    J_NEXT,
    J_DISPATCH,
    J_END
  } jmp_e;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_ADD,
    UPD_FUNC,
    UPD_ROLLBACK
  } upd_e;

  typedef logic [3:0] pc_t;

  localparam pc_t PC_DISPATCH = 4'd0;
  localparam pc_t PC_VERTEX   = 4'd1;
  localparam pc_t PC_COMMAND  = 4'd11;
  localparam pc_t PC_STATUS   = 4'd12;
  localparam pc_t PC_ROLLBACK = 4'd13;

  typedef struct packed {
    oksel_e     sel;
    logic [2:0] sub;
    jmp_e       jmp;
    upd_e       upd;
    logic       last;
  } ctrl_t;

  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t c;
    c = '{sel: OS_NONE, sub: 3'd0, jmp: J_NEXT, upd: UPD_NONE, last: 1'b0};
    case (pc)
      4'd0:  c.jmp = J_DISPATCH;
      4'd1:  begin c.sel = OS_VERTEX; c.sub = 3'd0; end
      4'd2:  begin c.sel = OS_VERTEX; c.sub = 3'd1; end
      4'd3:  begin c.sel = OS_VERTEX; c.sub = 3'd2; end
      4'd4:  begin c.sel = OS_VERTEX; c.sub = 3'd3; end
      4'd5:  begin c.sel = OS_INDEX;  c.sub = 3'd0; end
      4'd6:  begin c.sel = OS_INDEX;  c.sub = 3'd1; end
      4'd7:  begin c.sel = OS_INDEX;  c.sub = 3'd2; end
      4'd8:  begin c.sel = OS_INDEX;  c.sub = 3'd3; end
      4'd9:  begin c.sel = OS_INDEX;  c.sub = 3'd4; end
      4'd10: begin c.sel = OS_INDEX;  c.sub = 3'd5; end
      4'd11: begin
        c.sel = OS_COMMAND; c.jmp = J_END; c.upd = UPD_ADD; c.last = 1'b1;
      end
      4'd12: begin
        c.sel = OS_STATUS; c.jmp = J_END; c.upd = UPD_FUNC; c.last = 1'b1;
      end
      4'd13: begin
        c.sel = OS_ROLLBACK; c.jmp = J_END; c.upd = UPD_ROLLBACK; c.last = 1'b1;
      end
      default: c.jmp = J_END;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] quad_pattern(logic [2:0] k);
    logic [1:0] v;
    case (k)
      3'd0:    v = 2'd0;
      3'd1:    v = 2'd1;
      3'd2:    v = 2'd2;
      3'd3:    v = 2'd0;
      3'd4:    v = 2'd2;
      3'd5:    v = 2'd3;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* design/quad_draw_list_builder.sv */
`default_nettype none
// Indexed quad draw list builder. Each request on the slave stream carries a function in
// tuser (add rectangle, mark, rollback, clear) and the rectangle in tdata; the block answers
// with the store writes on the master stream, tlast on the final one. An accepted rectangle
// gives four vertex writes, six index writes and one command write or command length update;
// a refused one, and every other function, gives a single result. A small microcode program
// runs one step per cycle unless a result stalls at the master: one decode step, then one
// step per result. tready stays low while busy and rises in the cycle after the final
// result is loaded, so a new request waits until the last one is through.
// Budgets are written over the APB port at 0x0 (vertices), 0x4 (indices) and 0x8 (commands);
// the user must write them only while idle, as the block itself does not enforce this.
module quad_draw_list_builder #(
  parameter int VERTEX_DEPTH  = 65536,
  parameter int INDEX_DEPTH   = 131072,
  parameter int COMMAND_DEPTH = 4096
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // rect_x, rect_y, rect_width, rect_height, tex_left, tex_top, tex_width, tex_height,
  // packed_color, draw_mode, clip_tag, zero pad
  input  wire logic [183:0] s_axis_tdata_i,
  // func
  input  wire logic [1:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // write_address, pos_x, pos_y, tex_u, tex_v, vertex_color, vertex_mode, word_value,
  // command_clip, status, zero pad
  output logic      [159:0] m_axis_tdata_o,
  // kind
  output logic      [2:0]   m_axis_tuser_o,
  output logic              m_axis_tlast_o
);
  import qdlb_pkg::*;

  logic [16:0] vb_q;
  logic [17:0] ib_q;
  logic [12:0] cb_q;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= VERTEX_BUDGET_RST;
      ib_q <= INDEX_BUDGET_RST;
      cb_q <= COMMAND_BUDGET_RST;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[3:2]))
        CFG_VERTEX_BUDGET:  vb_q <= pwdata[16:0];
        CFG_INDEX_BUDGET:   ib_q <= pwdata[17:0];
        CFG_COMMAND_BUDGET: cb_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[3:2]))
      CFG_VERTEX_BUDGET:  prdata = {15'd0, vb_q};
      CFG_INDEX_BUDGET:   prdata = {14'd0, ib_q};
      CFG_COMMAND_BUDGET: prdata = {19'd0, cb_q};
      default:            prdata = '0;
    endcase
  end

  logic [19:0] vb_eff, ib_eff, cb_eff;
  assign vb_eff = ({3'd0, vb_q} < 20'(VERTEX_DEPTH))  ? {3'd0, vb_q} : 20'(VERTEX_DEPTH);
  assign ib_eff = ({2'd0, ib_q} < 20'(INDEX_DEPTH))   ? {2'd0, ib_q} : 20'(INDEX_DEPTH);
  assign cb_eff = ({7'd0, cb_q} < 20'(COMMAND_DEPTH)) ? {7'd0, cb_q} : 20'(COMMAND_DEPTH);

  // Latched request
  func_e              func_q;
  logic signed [15:0] x_q, y_q, w_q, h_q, tl_q, tt_q, tw_q, th_q;
  logic [31:0]        color_q;
  logic [1:0]         mode_q;
  logic [15:0]        clip_q;

  // List state
  logic [16:0] vcnt_q, vcnt_d;
  logic [17:0] icnt_q, icnt_d;
  logic [12:0] ccnt_q, ccnt_d;
  logic [16:0] lfirst_q, lfirst_d;
  logic [17:0] llen_q, llen_d;
  logic [15:0] lclip_q, lclip_d;
  logic        mvalid_q, mvalid_d;
  logic [16:0] mvcnt_q, mvcnt_d;
  logic [17:0] micnt_q, micnt_d;
  logic [12:0] mccnt_q, mccnt_d;
  logic [17:0] mlen_q, mlen_d;
  logic [16:0] mfirst_q, mfirst_d;
  logic [15:0] mclip_q, mclip_d;

  // Sequencer
  logic  busy_q, busy_d;
  pc_t   pc_q, pc_d;
  ctrl_t ctrl;
  assign ctrl = ucode(pc_q);

  logic in_fire;
  assign s_axis_tready_o = !busy_q;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  // Checks
  logic    deg, err_v, err_i, err_c, fresh, bad_mark;
  status_e add_status, step_status;
  assign deg   = (w_q <= 16'sd0) || (h_q <= 16'sd0);
  assign err_v = ({3'd0, vcnt_q} + 20'(QUAD_VERTS)) > vb_eff;
  assign err_i = ({2'd0, icnt_q} + 20'(QUAD_INDICES)) > ib_eff;
  assign fresh = (ccnt_q == 13'd0) || (lclip_q != clip_q);
  assign err_c = fresh && ({7'd0, ccnt_q} >= cb_eff);
  assign bad_mark = !mvalid_q || (mvcnt_q > vcnt_q) || (micnt_q > icnt_q) ||
                    (mccnt_q > ccnt_q);

  always_comb begin
    if (deg)        add_status = ST_DEGENERATE;
    else if (err_v) add_status = ST_VERTEX;
    else if (err_i) add_status = ST_INDEX;
    else if (err_c) add_status = ST_COMMAND;
    else            add_status = ST_OK;
  end

  always_comb begin
    case (func_q)
      FUNC_ADD:      step_status = add_status;
      FUNC_ROLLBACK: step_status = ST_BAD_MARK;
      default:       step_status = ST_OK;
    endcase
  end

  // Result datapath
  logic signed [16:0] px, py, tu, tv;
  logic [1:0]         corner;
  assign corner = ctrl.sub[1:0];
  assign px = 17'(x_q)  + (((corner == 2'd1) || (corner == 2'd2)) ? 17'(w_q)  : 17'sd0);
  assign py = 17'(y_q)  + (corner[1] ? 17'(h_q)  : 17'sd0);
  assign tu = 17'(tl_q) + (((corner == 2'd1) || (corner == 2'd2)) ? 17'(tw_q) : 17'sd0);
  assign tv = 17'(tt_q) + (corner[1] ? 17'(th_q) : 17'sd0);

  logic [17:0] llen_add;
  assign llen_add = llen_q + 18'(QUAD_INDICES);

  kind_e       r_kind;
  logic [16:0] r_addr;
  logic [16:0] r_px, r_py, r_tu, r_tv;
  logic [31:0] r_color;
  logic [1:0]  r_mode;
  logic [17:0] r_word;
  logic [15:0] r_clip;
  status_e     r_status;
  logic        emit;

  always_comb begin
    r_kind   = KIND_STATUS;
    r_addr   = '0;
    r_px     = '0;
    r_py     = '0;
    r_tu     = '0;
    r_tv     = '0;
    r_color  = '0;
    r_mode   = '0;
    r_word   = '0;
    r_clip   = '0;
    r_status = ST_OK;
    emit     = 1'b1;
    case (ctrl.sel)
      OS_VERTEX: begin
        r_kind  = KIND_VERTEX;
        r_addr  = vcnt_q + 17'(ctrl.sub);
        r_px    = px;
        r_py    = py;
        r_tu    = tu;
        r_tv    = tv;
        r_color = color_q;
        r_mode  = mode_q;
      end
      OS_INDEX: begin
        r_kind = KIND_INDEX;
        r_addr = 17'(icnt_q + 18'(ctrl.sub));
        r_word = {1'b0, vcnt_q} + 18'(quad_pattern(ctrl.sub));
      end
      OS_COMMAND: begin
        if (fresh) begin
          r_kind = KIND_NEW_CMD;
          r_addr = 17'(ccnt_q);
          r_word = icnt_q;
          r_clip = clip_q;
        end else begin
          r_kind = KIND_CMD_UPD;
          r_addr = 17'(ccnt_q - 13'd1);
          r_word = llen_add;
        end
      end
      OS_STATUS: r_status = step_status;
      OS_ROLLBACK: begin
        if (mccnt_q != 13'd0) begin
          r_kind = KIND_CMD_UPD;
          r_addr = 17'(mccnt_q - 13'd1);
          r_word = mlen_q;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // Output register
  logic         out_valid_q, out_valid_d;
  logic [159:0] out_data_q;
  logic [2:0]   out_kind_q;
  logic         out_last_q;
  logic         load, step;

  assign load = busy_q && emit && (!out_valid_q || m_axis_tready_i);
  assign step = busy_q && (!emit || load);

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (load)            out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= {4'd0, r_status, r_clip, r_word, r_mode, r_color,
                     r_tv, r_tu, r_py, r_px, r_addr};
      out_kind_q <= r_kind;
      out_last_q <= ctrl.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // Next step
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (in_fire) begin
      busy_d = 1'b1;
      pc_d   = PC_DISPATCH;
    end else if (step) begin
      case (ctrl.jmp)
        J_DISPATCH: begin
          case (func_q)
            FUNC_ADD:      pc_d = (add_status == ST_OK) ? PC_VERTEX : PC_STATUS;
            FUNC_ROLLBACK: pc_d = bad_mark ? PC_STATUS : PC_ROLLBACK;
            default:       pc_d = PC_STATUS;
          endcase
        end
        J_END:   busy_d = 1'b0;
        default: pc_d = pc_q + 4'd1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= PC_DISPATCH;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q  <= func_e'(s_axis_tuser_i);
      x_q     <= s_axis_tdata_i[15:0];
      y_q     <= s_axis_tdata_i[31:16];
      w_q     <= s_axis_tdata_i[47:32];
      h_q     <= s_axis_tdata_i[63:48];
      tl_q    <= s_axis_tdata_i[79:64];
      tt_q    <= s_axis_tdata_i[95:80];
      tw_q    <= s_axis_tdata_i[111:96];
      th_q    <= s_axis_tdata_i[127:112];
      color_q <= s_axis_tdata_i[159:128];
      mode_q  <= s_axis_tdata_i[161:160];
      clip_q  <= s_axis_tdata_i[177:162];
    end
  end

  // State update on the final step
  logic upd_add, upd_mark, upd_clear, upd_roll;
  assign upd_add   = load && (ctrl.upd == UPD_ADD);
  assign upd_roll  = load && (ctrl.upd == UPD_ROLLBACK);
  assign upd_mark  = load && (ctrl.upd == UPD_FUNC) && (func_q == FUNC_MARK);
  assign upd_clear = load && (ctrl.upd == UPD_FUNC) && (func_q == FUNC_CLEAR);

  always_comb begin
    vcnt_d   = vcnt_q;
    icnt_d   = icnt_q;
    ccnt_d   = ccnt_q;
    lfirst_d = lfirst_q;
    llen_d   = llen_q;
    lclip_d  = lclip_q;
    mvalid_d = mvalid_q;
    mvcnt_d  = mvcnt_q;
    micnt_d  = micnt_q;
    mccnt_d  = mccnt_q;
    mlen_d   = mlen_q;
    mfirst_d = mfirst_q;
    mclip_d  = mclip_q;
    if (upd_add) begin
      vcnt_d = vcnt_q + 17'(QUAD_VERTS);
      icnt_d = icnt_q + 18'(QUAD_INDICES);
      if (fresh) begin
        lfirst_d = 17'(icnt_q);
        llen_d   = 18'(QUAD_INDICES);
        lclip_d  = clip_q;
        ccnt_d   = ccnt_q + 13'd1;
      end else begin
        llen_d = llen_add;
      end
    end
    if (upd_mark) begin
      mvalid_d = 1'b1;
      mvcnt_d  = vcnt_q;
      micnt_d  = icnt_q;
      mccnt_d  = ccnt_q;
      mlen_d   = (ccnt_q != 13'd0) ? llen_q   : '0;
      mfirst_d = (ccnt_q != 13'd0) ? lfirst_q : '0;
      mclip_d  = (ccnt_q != 13'd0) ? lclip_q  : '0;
    end
    if (upd_roll) begin
      vcnt_d   = mvcnt_q;
      icnt_d   = micnt_q;
      ccnt_d   = mccnt_q;
      lfirst_d = mfirst_q;
      llen_d   = mlen_q;
      lclip_d  = mclip_q;
    end
    if (upd_clear) begin
      vcnt_d   = '0;
      icnt_d   = '0;
      ccnt_d   = '0;
      lfirst_d = '0;
      llen_d   = '0;
      lclip_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q   <= '0;
      icnt_q   <= '0;
      ccnt_q   <= '0;
      lfirst_q <= '0;
      llen_q   <= '0;
      lclip_q  <= '0;
      mvalid_q <= 1'b0;
      mvcnt_q  <= '0;
      micnt_q  <= '0;
      mccnt_q  <= '0;
      mlen_q   <= '0;
      mfirst_q <= '0;
      mclip_q  <= '0;
    end else begin
      vcnt_q   <= vcnt_d;
      icnt_q   <= icnt_d;
      ccnt_q   <= ccnt_d;
      lfirst_q <= lfirst_d;
      llen_q   <= llen_d;
      lclip_q  <= lclip_d;
      mvalid_q <= mvalid_d;
      mvcnt_q  <= mvcnt_d;
      micnt_q  <= micnt_d;
      mccnt_q  <= mccnt_d;
      mlen_q   <= mlen_d;
      mfirst_q <= mfirst_d;
      mclip_q  <= mclip_d;
    end
  end

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= PC_ROLLBACK))
    else $error("sequencer left its program");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && ctrl.last) |=> !busy_q)
    else $error("request still busy after its final result");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && emit && out_valid_q && !m_axis_tready_i) |=> $stable(pc_q))
    else $error("sequencer advanced over a stalled result");

  a_add_indices: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_add |=> (icnt_q == $past(icnt_q) + 18'(QUAD_INDICES)))
    else $error("index count not advanced by one quad");

  a_mark_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(mvalid_q))
    else $error("mark lost");

endmodule
`default_nettype wire
